[rtl/mtf_pkg.sv]
package mtf_pkg;

    // Default sizes of the list
    localparam int LIST_CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF      = 32;

    // Fixed field widths of the channels
    localparam int SYMBOL_BITS   = 32;
    localparam int POSITION_BITS = 6;
    localparam int STATUS_BITS   = 2;

    // Position width on the cell control bus, wide enough for the largest list
    localparam int CTRL_POS_W  = 10;
    localparam int CTRL_FILL_W = CTRL_POS_W + 1;

    // Request codes
    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_FOUND        = 2'd0,
        ST_NEW          = 2'd1,
        ST_FULL         = 2'd2,
        ST_OUT_OF_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_SELECT,
        S_SHIFT
    } t_state;

    // Compare phase: every cell checks its entry against the request
    typedef struct packed {
        logic                     capture;
        logic                     is_decode;
        logic [CTRL_FILL_W-1:0]   fill;
        logic [POSITION_BITS-1:0] position;
    } t_cell_match;

    // Update phase: cells in (dest, pos] take their left neighbor, dest takes the key
    typedef struct packed {
        logic                  update;
        logic [CTRL_POS_W-1:0] pos;
        logic                  dest_one;
    } t_cell_ctrl;

endpackage

[rtl/mtf_in_if.sv]
interface mtf_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   req_type;
    logic [mtf_pkg::SYMBOL_BITS-1:0]        symbol_key;
    logic [mtf_pkg::POSITION_BITS-1:0]      list_position;

    modport source (output valid, req_type, symbol_key, list_position, input ready);
    modport sink   (input valid, req_type, symbol_key, list_position, output ready);
endinterface

[rtl/mtf_out_if.sv]
interface mtf_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [mtf_pkg::STATUS_BITS-1:0]        status;
    logic [mtf_pkg::POSITION_BITS-1:0]      found_position;
    logic [mtf_pkg::SYMBOL_BITS-1:0]        found_key;

    modport source (output valid, status, found_position, found_key, input ready);
    modport sink   (input valid, status, found_position, found_key, output ready);
endinterface

[rtl/mtf_cell.sv]
module mtf_cell #(
    parameter int KEY_BITS = mtf_pkg::KEY_BITS_DEF,
    parameter int IDX      = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mtf_pkg::t_cell_match i_match,
    input  mtf_pkg::t_cell_ctrl  i_ctrl,
    input  logic [KEY_BITS-1:0]  i_search_key,
    input  logic [KEY_BITS-1:0]  i_load_key,
    input  logic [KEY_BITS-1:0]  i_left_key,
    output logic [KEY_BITS-1:0]  o_key,
    output logic                 o_hit
);

    localparam int PW = mtf_pkg::CTRL_POS_W;
    localparam int FW = mtf_pkg::CTRL_FILL_W;
    localparam logic [PW-1:0] C_IDX = PW'(IDX);

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    logic                r_hit;
    logic                n_hit;
    logic                w_filled;
    logic [PW-1:0]       w_dest;

    assign w_filled = FW'(C_IDX) < i_match.fill;
    assign w_dest   = PW'(i_ctrl.dest_one);

    // Flag this entry when it holds the key or sits at the decode position
    always_comb begin
        n_hit = r_hit;
        if (i_match.capture) begin
            if (i_match.is_decode) begin
                n_hit = w_filled && (C_IDX == PW'(i_match.position));
            end else begin
                n_hit = w_filled && (r_key == i_search_key);
            end
        end
    end

    // Take the promoted key, shift in from the left, or hold
    always_comb begin
        n_key = r_key;
        if (i_ctrl.update) begin
            if (C_IDX == w_dest) begin
                n_key = i_load_key;
            end else if (C_IDX > w_dest && C_IDX <= i_ctrl.pos) begin
                n_key = i_left_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_key = r_key;
    assign o_hit = r_hit;

endmodule

[rtl/move_to_front_list_top.sv]
// The sequencer runs the compare, select and shift steps over the cell chain
// for each accepted input transaction before the result is registered valid;
// a new request is accepted only once the chain is back in its idle step.
// A stalled result holds the chain in its shift step until the output frees.
// Reset (synchronous, active low) clears the fill count, the mode register and
// the handshake state; list entries stay undefined until written.
module move_to_front_list_top #(
    parameter int LIST_CAPACITY = mtf_pkg::LIST_CAPACITY_DEF,
    parameter int KEY_BITS      = mtf_pkg::KEY_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    mtf_in_if.sink           i_in,
    mtf_out_if.source        o_out
);

    localparam int IDX_W  = $clog2(LIST_CAPACITY);
    localparam int FILL_W = $clog2(LIST_CAPACITY + 1);
    localparam int PW     = mtf_pkg::CTRL_POS_W;
    localparam int FW     = mtf_pkg::CTRL_FILL_W;
    localparam int POS_B  = mtf_pkg::POSITION_BITS;
    localparam int SYM_B  = mtf_pkg::SYMBOL_BITS;

    mtf_pkg::t_state      r_state;
    mtf_pkg::t_state      n_state;

    logic                 r_mtf1;
    logic [FILL_W-1:0]    r_fill;

    // Request registers
    logic                 r_req_type;
    logic [KEY_BITS-1:0]  r_want;
    logic [POS_B-1:0]     r_req_pos;

    // Selection results
    logic                 r_upd;
    logic                 r_new;
    logic [IDX_W-1:0]     r_pos;
    logic [KEY_BITS-1:0]  r_sel_key;
    mtf_pkg::t_status     r_status;
    logic [POS_B-1:0]     w_rep_pos;

    // Output register
    logic                 r_out_valid;
    mtf_pkg::t_status     r_out_status;
    logic [POS_B-1:0]     r_out_pos;
    logic [KEY_BITS-1:0]  r_out_key;

    logic                 w_in_accept;
    logic                 w_out_free;
    logic                 w_capture;
    logic                 w_select;
    logic                 w_commit;

    logic [63:0]          w_sym_ext;
    logic [KEY_BITS-1:0]  w_want;
    logic [63:0]          w_key_ext;

    logic [KEY_BITS-1:0]  w_keys [LIST_CAPACITY];
    logic [KEY_BITS-1:0]  w_left [LIST_CAPACITY];
    logic [LIST_CAPACITY-1:0] w_hit;

    logic                 w_hit_any;
    logic [IDX_W-1:0]     w_hit_pos;
    logic [KEY_BITS-1:0]  w_hit_key;
    logic [PW-1:0]        w_pos_wide;

    mtf_pkg::t_cell_match w_match;
    mtf_pkg::t_cell_ctrl  w_ctrl;

    assign w_sym_ext = 64'(i_in.symbol_key);
    assign w_want    = w_sym_ext[KEY_BITS-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtf_pkg::S_IDLE:   if (i_in.valid) n_state = mtf_pkg::S_MATCH;
            mtf_pkg::S_MATCH:  n_state = mtf_pkg::S_SELECT;
            mtf_pkg::S_SELECT: n_state = mtf_pkg::S_SHIFT;
            mtf_pkg::S_SHIFT:  if (w_out_free) n_state = mtf_pkg::S_IDLE;
            default:           n_state = mtf_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        i_in.ready = 1'b0;
        w_capture  = 1'b0;
        w_select   = 1'b0;
        w_commit   = 1'b0;
        unique case (r_state)
            mtf_pkg::S_IDLE:   i_in.ready = 1'b1;
            mtf_pkg::S_MATCH:  w_capture  = 1'b1;
            mtf_pkg::S_SELECT: w_select   = 1'b1;
            mtf_pkg::S_SHIFT:  w_commit   = w_out_free;
            default:           i_in.ready = 1'b0;
        endcase
    end

    assign w_in_accept = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtf1 <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mtf1 <= i_cfg_wr_data;
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_req_type <= i_in.req_type;
            r_want     <= w_want;
            r_req_pos  <= i_in.list_position;
        end
    end

    // Cell chain
    assign w_match.capture   = w_capture;
    assign w_match.is_decode = (r_req_type == mtf_pkg::REQ_DECODE);
    assign w_match.fill      = FW'(r_fill);
    assign w_match.position  = r_req_pos;

    assign w_ctrl.update   = w_commit && r_upd;
    assign w_ctrl.pos      = PW'(r_pos);
    assign w_ctrl.dest_one = r_mtf1 && (r_pos > IDX_W'(1));

    for (genvar g = 0; g < LIST_CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g] = '0;
        end else begin : g_body
            assign w_left[g] = w_keys[g-1];
        end

        mtf_cell #(
            .KEY_BITS (KEY_BITS),
            .IDX      (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_match      (w_match),
            .i_ctrl       (w_ctrl),
            .i_search_key (r_want),
            .i_load_key   (r_sel_key),
            .i_left_key   (w_left[g]),
            .o_key        (w_keys[g]),
            .o_hit        (w_hit[g])
        );
    end

    // Merge the one-hot hit flags into a position and a key
    always_comb begin
        w_hit_any = 1'b0;
        w_hit_pos = '0;
        w_hit_key = '0;
        for (int i = 0; i < LIST_CAPACITY; i++) begin
            if (w_hit[i]) begin
                w_hit_any = 1'b1;
                w_hit_pos = w_hit_pos | IDX_W'(i);
                w_hit_key = w_hit_key | w_keys[i];
            end
        end
    end

    // Decide status and the promotion to apply
    always_ff @(posedge i_clk) begin
        if (w_select) begin
            r_upd     <= 1'b0;
            r_new     <= 1'b0;
            r_pos     <= w_hit_pos;
            r_sel_key <= w_hit_key;
            r_status  <= mtf_pkg::ST_FOUND;
            if (w_hit_any) begin
                r_upd <= 1'b1;
            end else if (r_req_type == mtf_pkg::REQ_DECODE) begin
                r_status  <= mtf_pkg::ST_OUT_OF_RANGE;
                r_sel_key <= '0;
            end else if (r_fill < FILL_W'(LIST_CAPACITY)) begin
                r_upd     <= 1'b1;
                r_new     <= 1'b1;
                r_pos     <= IDX_W'(r_fill);
                r_sel_key <= r_want;
                r_status  <= mtf_pkg::ST_NEW;
            end else begin
                r_pos     <= '0;
                r_sel_key <= '0;
                r_status  <= mtf_pkg::ST_FULL;
            end
        end
    end

    assign w_pos_wide = PW'(r_pos);

    always_comb begin
        w_rep_pos = w_pos_wide[POS_B-1:0];
        if (r_status == mtf_pkg::ST_OUT_OF_RANGE) begin
            w_rep_pos = r_req_pos;
        end
    end

    // Grow the list on an appended key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_commit && r_new) begin
            r_fill <= r_fill + FILL_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_status <= r_status;
            r_out_pos    <= w_rep_pos;
            r_out_key    <= r_sel_key;
        end
    end

    assign w_key_ext            = 64'(r_out_key);
    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.found_position = r_out_pos;
    assign o_out.found_key      = w_key_ext[SYM_B-1:0];

    // A result appears only out of the shift step
    a_result_from_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == mtf_pkg::S_SHIFT))
        else $error("result valid rose outside the shift step");

    // At most one cell flags a hit
    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtf_pkg::S_SELECT) |-> $onehot0(w_hit))
        else $error("more than one cell hit");

    // The fill count never passes the capacity
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(LIST_CAPACITY))
        else $error("fill count beyond capacity");

    // A rejected key only when the list is full
    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtf_pkg::S_SHIFT && r_status == mtf_pkg::ST_FULL)
            |-> (r_fill == FILL_W'(LIST_CAPACITY)))
        else $error("key rejected while list has room");

endmodule
